### rtl/core/nnfd_pkg.sv
// ============================================================================
// nnfd_pkg
// Shared types, constants and helper functions of the nearest-neighbor fit
// downscaler.
// ============================================================================
`default_nettype none

package nnfd_pkg;

    // Widths of the sizes, the pixel word and the rational accumulators.
    localparam int SIDE_W = 13;
    localparam int ACC_W  = 26;
    localparam int PIX_W  = 32;

    // Largest side that the block handles; larger register values saturate.
    localparam logic [SIDE_W-1:0] MAX_SIDE = 13'd4096;

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_MAX_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAX_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [SIDE_W-1:0] max_width;
        logic [SIDE_W-1:0] max_height;
        logic [SIDE_W-1:0] image_width;
        logic [SIDE_W-1:0] image_height;
    } cfg_t;

    // Position of a source pixel within its frame.
    typedef struct packed {
        logic first_frame;   // first pixel of a frame
        logic first_row;     // first pixel of a row
        logic end_row;       // last pixel of a row
        logic last_row;      // pixel lies in the last row
    } item_flags_t;

    // One classified pixel as it waits for the back part.
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        item_flags_t       flags;
        logic              resize_on;
        logic [SIDE_W-1:0] num;
        logic [SIDE_W-1:0] den;
        logic [ACC_W-1:0]  w_num;
        logic [ACC_W-1:0]  h_num;
    } work_item_t;

    // Image side: zero acts as one, values above the maximum saturate.
    function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0)
            r = {{(SIDE_W-1){1'b0}}, 1'b1};
        else if (v > MAX_SIDE)
            r = MAX_SIDE;
        else
            r = v;
        return r;
    endfunction

    // Size limit: values above the maximum saturate, zero stays zero.
    function automatic logic [SIDE_W-1:0] limit_of(input logic [SIDE_W-1:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/nnfd_front.sv
// ============================================================================
// nnfd_front
// Accepts source pixels, tracks their raster position and works out the
// scaling ratio and the scaled side lengths over three pipeline stages.
// ============================================================================
`default_nettype none

module nnfd_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [nnfd_pkg::PIX_W-1:0] in_pixel,
    input  wire nnfd_pkg::cfg_t           cfg,
    input  wire logic                     queue_full,
    output logic                          push,
    output nnfd_pkg::work_item_t          push_item
);

    typedef struct packed {
        logic [nnfd_pkg::PIX_W-1:0]  pixel;
        nnfd_pkg::item_flags_t       flags;
        logic [nnfd_pkg::SIDE_W-1:0] w;
        logic [nnfd_pkg::SIDE_W-1:0] h;
        logic [nnfd_pkg::SIDE_W-1:0] mw;
        logic [nnfd_pkg::SIDE_W-1:0] mh;
    } stage_a_t;

    typedef struct packed {
        logic [nnfd_pkg::PIX_W-1:0]  pixel;
        nnfd_pkg::item_flags_t       flags;
        logic [nnfd_pkg::SIDE_W-1:0] w;
        logic [nnfd_pkg::SIDE_W-1:0] h;
        logic [nnfd_pkg::SIDE_W-1:0] nx;
        logic [nnfd_pkg::SIDE_W-1:0] dx;
        logic [nnfd_pkg::SIDE_W-1:0] ny;
        logic [nnfd_pkg::SIDE_W-1:0] dy;
        logic                        resize_on;
        logic [nnfd_pkg::ACC_W-1:0]  px;
        logic [nnfd_pkg::ACC_W-1:0]  py;
    } stage_b_t;

    typedef struct packed {
        logic [nnfd_pkg::PIX_W-1:0]  pixel;
        nnfd_pkg::item_flags_t       flags;
        logic [nnfd_pkg::SIDE_W-1:0] w;
        logic [nnfd_pkg::SIDE_W-1:0] h;
        logic [nnfd_pkg::SIDE_W-1:0] num;
        logic [nnfd_pkg::SIDE_W-1:0] den;
        logic                        resize_on;
    } stage_c_t;

    localparam logic [nnfd_pkg::SIDE_W-1:0] ONE = {{(nnfd_pkg::SIDE_W-1){1'b0}}, 1'b1};

    logic                        adv;
    logic                        accept;
    logic [nnfd_pkg::SIDE_W-1:0] src_col_reg, src_col_next;
    logic [nnfd_pkg::SIDE_W-1:0] src_row_reg, src_row_next;
    logic [nnfd_pkg::SIDE_W-1:0] w_live, h_live;
    nnfd_pkg::item_flags_t       flags_in;

    logic     a_valid_reg, b_valid_reg, c_valid_reg;
    stage_a_t a_reg, a_next;
    stage_b_t b_reg, b_next;
    stage_c_t c_reg, c_next;

    logic [nnfd_pkg::SIDE_W-1:0] ratio_num_reg, ratio_num_next;
    logic [nnfd_pkg::SIDE_W-1:0] ratio_den_reg, ratio_den_next;
    logic                        ratio_rs_reg, ratio_rs_next;
    logic [nnfd_pkg::SIDE_W-1:0] num_use, den_use;
    logic                        rs_use;

    // The whole front moves as one shift line; it holds only when its last
    // stage has an item that the queue cannot take.
    assign adv      = !c_valid_reg || !queue_full;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // Raster position against the live image size.
    always_comb
    begin
        w_live               = nnfd_pkg::side_of(cfg.image_width);
        h_live               = nnfd_pkg::side_of(cfg.image_height);
        flags_in.first_row   = (src_col_reg == '0);
        flags_in.first_frame = (src_col_reg == '0) && (src_row_reg == '0);
        flags_in.end_row     = ({1'b0, src_col_reg} + 14'd1) >= {1'b0, w_live};
        flags_in.last_row    = ({1'b0, src_row_reg} + 14'd1) >= {1'b0, h_live};
        src_col_next         = flags_in.end_row ? '0 : src_col_reg + ONE;
        src_row_next         = src_row_reg;
        if (flags_in.end_row)
        begin
            src_row_next = flags_in.last_row ? '0 : src_row_reg + ONE;
        end
    end

    // Stage A: capture the pixel with its position and the clamped sizes.
    always_comb
    begin
        a_next.pixel = in_pixel;
        a_next.flags = flags_in;
        a_next.w     = w_live;
        a_next.h     = h_live;
        a_next.mw    = nnfd_pkg::limit_of(cfg.max_width);
        a_next.mh    = nnfd_pkg::limit_of(cfg.max_height);
    end

    // Stage B: candidate ratios and their cross products.
    always_comb
    begin
        b_next.pixel     = a_reg.pixel;
        b_next.flags     = a_reg.flags;
        b_next.w         = a_reg.w;
        b_next.h         = a_reg.h;
        b_next.resize_on = ((a_reg.mw != '0) && (a_reg.w > a_reg.mw)) ||
                           ((a_reg.mh != '0) && (a_reg.h > a_reg.mh));
        b_next.nx        = (a_reg.mw != '0) ? a_reg.mw : ONE;
        b_next.dx        = (a_reg.mw != '0) ? a_reg.w  : ONE;
        b_next.ny        = (a_reg.mh != '0) ? a_reg.mh : ONE;
        b_next.dy        = (a_reg.mh != '0) ? a_reg.h  : ONE;
        b_next.px        = {13'd0, b_next.nx} * {13'd0, b_next.dy};
        b_next.py        = {13'd0, b_next.ny} * {13'd0, b_next.dx};
    end

    // Stage C: pick the smaller ratio; the width ratio wins a tie.
    always_comb
    begin
        c_next.pixel     = b_reg.pixel;
        c_next.flags     = b_reg.flags;
        c_next.w         = b_reg.w;
        c_next.h         = b_reg.h;
        c_next.resize_on = b_reg.resize_on;
        if (!b_reg.resize_on)
        begin
            c_next.num = ONE;
            c_next.den = ONE;
        end
        else if (b_reg.px <= b_reg.py)
        begin
            c_next.num = b_reg.nx;
            c_next.den = b_reg.dx;
        end
        else
        begin
            c_next.num = b_reg.ny;
            c_next.den = b_reg.dy;
        end
    end

    // The ratio is latched by the first pixel of a frame and then holds.
    always_comb
    begin
        num_use        = c_reg.flags.first_frame ? c_reg.num : ratio_num_reg;
        den_use        = c_reg.flags.first_frame ? c_reg.den : ratio_den_reg;
        rs_use         = c_reg.flags.first_frame ? c_reg.resize_on : ratio_rs_reg;
        ratio_num_next = ratio_num_reg;
        ratio_den_next = ratio_den_reg;
        ratio_rs_next  = ratio_rs_reg;
        if (push && c_reg.flags.first_frame)
        begin
            ratio_num_next = c_reg.num;
            ratio_den_next = c_reg.den;
            ratio_rs_next  = c_reg.resize_on;
        end
    end

    assign push = adv && c_valid_reg;

    always_comb
    begin
        push_item.pixel     = c_reg.pixel;
        push_item.flags     = c_reg.flags;
        push_item.resize_on = rs_use;
        push_item.num       = num_use;
        push_item.den       = den_use;
        push_item.w_num     = {13'd0, c_reg.w} * {13'd0, num_use};
        push_item.h_num     = {13'd0, c_reg.h} * {13'd0, num_use};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            ratio_num_reg <= ONE;
            ratio_den_reg <= ONE;
            ratio_rs_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                src_col_reg <= src_col_next;
                src_row_reg <= src_row_next;
            end
            if (adv)
            begin
                a_valid_reg <= in_valid;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
            ratio_num_reg <= ratio_num_next;
            ratio_den_reg <= ratio_den_next;
            ratio_rs_reg  <= ratio_rs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    // A resizing ratio always shrinks the image.
    assert property (@(posedge clk) disable iff (!rst_n)
        ratio_rs_reg |-> (ratio_num_reg < ratio_den_reg))
        else $error("latched resize ratio does not shrink");

    // Without resizing the latched ratio is one to one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !ratio_rs_reg |-> (ratio_num_reg == ONE) && (ratio_den_reg == ONE))
        else $error("pass-through ratio is not one to one");

    // The first pixel of a frame is always the first pixel of a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_reg.flags.first_frame) |-> a_reg.flags.first_row)
        else $error("frame start outside column zero");

endmodule

`default_nettype wire

### rtl/core/nnfd_queue.sv
// ============================================================================
// nnfd_queue
// Short register queue of classified pixels between the front and the back.
// ============================================================================
`default_nettype none

module nnfd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire nnfd_pkg::work_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output nnfd_pkg::work_item_t      head
);

    nnfd_pkg::work_item_t              entry_reg [nnfd_pkg::QUEUE_DEPTH];
    logic [nnfd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [nnfd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [nnfd_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full       = (count_reg == nnfd_pkg::QCNT_W'(nnfd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + nnfd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + nnfd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + nnfd_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - nnfd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/core/nnfd_back.sv
// ============================================================================
// nnfd_back
// Runs the exact rational selection on each queued pixel and holds the kept
// pixels in the output register.
// ============================================================================
`default_nettype none

module nnfd_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_valid,
    input  wire nnfd_pkg::work_item_t       head,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [nnfd_pkg::PIX_W-1:0]      out_pixel,
    output logic                            out_last
);

    logic [nnfd_pkg::ACC_W-1:0] col_t_reg, col_t_next;
    logic [nnfd_pkg::ACC_W-1:0] col_p_reg, col_p_next;
    logic [nnfd_pkg::ACC_W-1:0] row_t_reg, row_t_next;
    logic [nnfd_pkg::ACC_W-1:0] row_p_reg, row_p_next;
    logic                       row_kept_reg, row_kept_next;
    logic                       out_valid_reg, out_valid_next;
    logic [nnfd_pkg::PIX_W-1:0] out_pixel_reg;
    logic                       out_last_reg;

    logic [nnfd_pkg::ACC_W-1:0] col_t, col_p, row_t, row_p;
    logic [nnfd_pkg::ACC_W-1:0] num_x, den_x, den_x2;
    logic                       row_hit, col_hit, keep, last;

    // Target in [pos, pos + num) and the output index inside the scaled side.
    function automatic logic picks(input logic [nnfd_pkg::ACC_W-1:0] pos,
                                   input logic [nnfd_pkg::ACC_W-1:0] tgt,
                                   input logic [nnfd_pkg::ACC_W-1:0] num,
                                   input logic [nnfd_pkg::ACC_W-1:0] den,
                                   input logic [nnfd_pkg::ACC_W-1:0] side_num);
        return (pos <= tgt) && (tgt < pos + num) && (tgt + den <= side_num);
    endfunction

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        num_x   = {13'd0, head.num};
        den_x   = {13'd0, head.den};
        den_x2  = {12'd0, head.den, 1'b0};
        row_t   = head.flags.first_frame ? '0 : row_t_reg;
        row_p   = head.flags.first_frame ? '0 : row_p_reg;
        col_t   = head.flags.first_row ? '0 : col_t_reg;
        col_p   = head.flags.first_row ? '0 : col_p_reg;
        row_hit = head.flags.first_row ?
                  (!head.resize_on || picks(row_p, row_t, num_x, den_x, head.h_num)) :
                  row_kept_reg;
        col_hit = head.resize_on && picks(col_p, col_t, num_x, den_x, head.w_num);
        if (head.resize_on)
        begin
            keep = row_hit && col_hit;
            last = (col_t + den_x2 > head.w_num) && (row_t + den_x2 > head.h_num);
        end
        else
        begin
            keep = 1'b1;
            last = head.flags.end_row && head.flags.last_row;
        end

        col_t_next = col_t;
        col_p_next = col_p;
        row_t_next = row_t;
        row_p_next = row_p;
        if (head.resize_on)
        begin
            if (col_hit)
                col_t_next = col_t + den_x;
            col_p_next = col_p + num_x;
            if (head.flags.end_row)
            begin
                if (row_hit)
                    row_t_next = row_t + den_x;
                row_p_next = row_p + num_x;
            end
        end
        row_kept_next = row_hit;

        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = keep;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_t_reg     <= '0;
            col_p_reg     <= '0;
            row_t_reg     <= '0;
            row_p_reg     <= '0;
            row_kept_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                col_t_reg    <= col_t_next;
                col_p_reg    <= col_p_next;
                row_t_reg    <= row_t_next;
                row_p_reg    <= row_p_next;
                row_kept_reg <= row_kept_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_pixel_reg <= head.pixel;
            out_last_reg  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

    // A waiting result is never overwritten by the next pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("pending output overwritten");

    // Pass-through frames leave the column accumulator at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.resize_on) |=> (col_p_reg == '0))
        else $error("column accumulator moved without resizing");

    // Pass-through frames leave the row target at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.resize_on) |=> (row_t_reg == '0))
        else $error("row target moved without resizing");

endmodule

`default_nettype wire

### rtl/core/nearest_neighbor_fit_downscaler_top.sv
// ============================================================================
// nearest_neighbor_fit_downscaler_top
// Nearest-neighbor downscaler that fits an RGBA raster frame into a maximum
// output size with one uniform ratio.
// ============================================================================
// Usage: source pixels of one image_width x image_height frame enter in raster
// order on the s_ stream, one item per accepted handshake. Kept pixels leave on
// the m_ stream; m_tlast marks the final output pixel of a frame. When either
// positive limit (max_width, max_height) is exceeded, the smaller of the two
// ratios is latched by the first pixel of the frame and only the nearest-
// neighbor source pixels of the scaled frame are passed; otherwise every pixel
// passes unchanged. Registers must be written through the APB port between
// frames; the block itself does not enforce this. An accepted item passes
// through the front stages, the queue entry and the output register before it
// reaches m_tdata. Throughput: one item per cycle while m_tready stays high.
// When the receiver stalls, the output register holds its item, the
// four-entry queue fills, and s_tready drops once the queue is full and the
// last front stage holds an item. Reset clears the raster position,
// accumulators, queue and output valid and loads the registers with no limits
// and a 1 x 1 frame; no item is lost or replayed across a stall.
// ============================================================================
`default_nettype none

module nearest_neighbor_fit_downscaler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Source pixels
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    // Kept pixels
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic             m_tlast,   // frame_last
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    nnfd_pkg::cfg_t       cfg_reg, cfg_next;
    logic                 cfg_write;
    logic [1:0]           reg_index;
    logic [nnfd_pkg::SIDE_W-1:0] wr_value;

    logic                 queue_full;
    logic                 push;
    nnfd_pkg::work_item_t push_item;
    logic                 pop;
    logic                 head_valid;
    nnfd_pkg::work_item_t head;

    // Register file: word address selects the register, data is 13 bits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];
    assign wr_value  = pwdata[nnfd_pkg::SIDE_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                nnfd_pkg::REG_MAX_WIDTH:    cfg_next.max_width    = wr_value;
                nnfd_pkg::REG_MAX_HEIGHT:   cfg_next.max_height   = wr_value;
                nnfd_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = wr_value;
                nnfd_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = wr_value;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            nnfd_pkg::REG_MAX_WIDTH:    prdata = {19'd0, cfg_reg.max_width};
            nnfd_pkg::REG_MAX_HEIGHT:   prdata = {19'd0, cfg_reg.max_height};
            nnfd_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_reg.image_width};
            nnfd_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_reg.image_height};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_width    <= '0;
            cfg_reg.max_height   <= '0;
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.image_height <= 13'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: raster tracking, ratio selection and scaled sides.
    nnfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pixel   (s_tdata),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Queue that lets the front keep accepting while the back stalls.
    nnfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: exact accumulator selection and the output register.
    nnfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

### dv/tb_nearest_neighbor_fit_downscaler_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_nearest_neighbor_fit_downscaler_top
// Self-checking bench for the nearest-neighbor fit downscaler. Source pixels
// stream in with bursty gaps while the sink stalls on its own schedule. An
// exact rational predictor decides which pixels survive the fit and which one
// closes the frame. Every kept item is compared field by field in order.
// ============================================================================

module tb_nearest_neighbor_fit_downscaler_top;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    // Items pass through the front stages, the queue and the output register;
    // items that are dropped still travel through the front stages, so give
    // them time to leave.
    localparam int SETTLE_CYCLES  = 16;
    // Cycles in a row with no handshake or register write before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 950;
    // Frames up to this many pixels are sent whole; larger ones only in part.
    localparam int SMALL_FRAME    = 96;

    // Receiver stall patterns.
    localparam int SINK_OPEN   = 0;   // always ready
    localparam int SINK_COIN   = 1;   // ready on a coin toss every cycle
    localparam int SINK_COMB   = 2;   // fixed comb of ready and stalled cycles
    localparam int SINK_BURSTY = 3;   // long stalls between short open windows

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_last;
    } kept_pixel_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // red_in, green_in, blue_in, alpha_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // red_out, green_out, blue_out, alpha_out
    logic        m_tlast;           // frame_last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    logic [31:0] pixel_q[$];        // source pixels not yet offered
    kept_pixel_t kept_q[$];         // predicted kept pixels, oldest first
    int          fail_count    = 0;
    int          items_sent    = 0;
    int          idle_cycles   = 0;
    int          items_offered = 0;  // counted by the driver
    int          items_taken   = 0;  // counted by the monitor

    // Sender burst and gap counters, receiver pattern state.
    int          burst_left    = 0;
    int          gap_left      = 0;
    int          sink_mode     = SINK_OPEN;
    int          sink_left     = 0;
    int          hold_left     = 0;
    bit          hold_ready    = 1'b0;

    // Shadow copy of the configuration registers, at their reset values.
    logic [nnfd_pkg::SIDE_W-1:0] cfg_max_w = '0;
    logic [nnfd_pkg::SIDE_W-1:0] cfg_max_h = '0;
    logic [nnfd_pkg::SIDE_W-1:0] cfg_img_w = nnfd_pkg::SIDE_W'(1);
    logic [nnfd_pkg::SIDE_W-1:0] cfg_img_h = nnfd_pkg::SIDE_W'(1);

    // Predictor copy of the raster position, the rational accumulators and
    // the ratio that the first pixel of a frame latches.
    logic [nnfd_pkg::SIDE_W-1:0] src_col   = '0;
    logic [nnfd_pkg::SIDE_W-1:0] src_row   = '0;
    logic [nnfd_pkg::ACC_W-1:0]  col_tgt   = '0;   // output column times den
    logic [nnfd_pkg::ACC_W-1:0]  col_pos   = '0;   // source column times num
    logic [nnfd_pkg::ACC_W-1:0]  row_tgt   = '0;   // output row times den
    logic [nnfd_pkg::ACC_W-1:0]  row_pos   = '0;   // source row times num
    logic                        row_kept  = 1'b0;
    logic [nnfd_pkg::SIDE_W-1:0] ratio_num = nnfd_pkg::SIDE_W'(1);
    logic [nnfd_pkg::SIDE_W-1:0] ratio_den = nnfd_pkg::SIDE_W'(1);
    logic                        scaling   = 1'b0;

    nearest_neighbor_fit_downscaler_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor helpers. Sizes of zero act as one and everything saturates at
    // the largest side; all products are formed at 64 bits so nothing wraps.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] clamp_side(input logic [nnfd_pkg::SIDE_W-1:0] v);
        if (v == '0)
            return 64'd1;
        if (v > nnfd_pkg::MAX_SIDE)
            return 64'(nnfd_pkg::MAX_SIDE);
        return 64'(v);
    endfunction

    function automatic logic [63:0] clamp_limit(input logic [nnfd_pkg::SIDE_W-1:0] v);
        return (v > nnfd_pkg::MAX_SIDE) ? 64'(nnfd_pkg::MAX_SIDE) : 64'(v);
    endfunction

    // A source index is picked when the output target lies in [pos, pos+num)
    // and the output index still falls inside the scaled side.
    function automatic logic picks_source(input logic [63:0] pos, input logic [63:0] tgt,
                                          input logic [63:0] side);
        return pos <= tgt && tgt < pos + 64'(ratio_num) &&
               tgt + 64'(ratio_den) <= side * 64'(ratio_num);
    endfunction

    // Advances the predictor by one accepted source pixel and records the
    // kept pixel, if any.
    task automatic downscale_pixel(input logic [31:0] pix);
        logic [63:0] w, h, mw, mh, nx, dx, ny, dy;
        logic        col_hit, keep, last;
        w       = clamp_side(cfg_img_w);
        h       = clamp_side(cfg_img_h);
        col_hit = 1'b0;
        last    = 1'b0;

        // The first pixel of a frame latches the ratio from the registers.
        if (src_col == '0 && src_row == '0)
        begin
            mw      = clamp_limit(cfg_max_w);
            mh      = clamp_limit(cfg_max_h);
            scaling = (mw != 0 && w > mw) || (mh != 0 && h > mh);
            if (!scaling)
            begin
                ratio_num = nnfd_pkg::SIDE_W'(1);
                ratio_den = nnfd_pkg::SIDE_W'(1);
            end
            else
            begin
                // A missing limit counts as a ratio of one.
                nx = (mw != 0) ? mw : 64'd1;
                dx = (mw != 0) ? w  : 64'd1;
                ny = (mh != 0) ? mh : 64'd1;
                dy = (mh != 0) ? h  : 64'd1;
                if (nx * dy <= ny * dx)
                begin
                    ratio_num = nnfd_pkg::SIDE_W'(nx);
                    ratio_den = nnfd_pkg::SIDE_W'(dx);
                end
                else
                begin
                    ratio_num = nnfd_pkg::SIDE_W'(ny);
                    ratio_den = nnfd_pkg::SIDE_W'(dy);
                end
            end
            row_tgt = '0;
            row_pos = '0;
        end
        if (src_col == '0)
        begin
            col_tgt  = '0;
            col_pos  = '0;
            row_kept = !scaling || picks_source(64'(row_pos), 64'(row_tgt), h);
        end

        if (scaling)
        begin
            col_hit = picks_source(64'(col_pos), 64'(col_tgt), w);
            keep    = row_kept && col_hit;
            if (keep)
                last = 64'(col_tgt) + 2 * 64'(ratio_den) > w * 64'(ratio_num) &&
                       64'(row_tgt) + 2 * 64'(ratio_den) > h * 64'(ratio_num);
        end
        else
        begin
            keep = 1'b1;
            last = 64'(src_col) + 1 >= w && 64'(src_row) + 1 >= h;
        end

        if (keep)
            kept_q.push_back(kept_pixel_t'{pix[7:0], pix[15:8], pix[23:16], pix[31:24],
                                           last});

        if (scaling)
        begin
            if (col_hit)
                col_tgt = col_tgt + nnfd_pkg::ACC_W'(ratio_den);
            col_pos = col_pos + nnfd_pkg::ACC_W'(ratio_num);
        end

        // A column at or beyond a freshly shrunk width wraps here as well.
        if (64'(src_col) + 1 >= w)
        begin
            src_col = '0;
            if (scaling)
            begin
                if (row_kept)
                    row_tgt = row_tgt + nnfd_pkg::ACC_W'(ratio_den);
                row_pos = row_pos + nnfd_pkg::ACC_W'(ratio_num);
            end
            if (64'(src_row) + 1 >= h)
                src_row = '0;
            else
                src_row = src_row + nnfd_pkg::SIDE_W'(1);
        end
        else
        begin
            src_col = src_col + nnfd_pkg::SIDE_W'(1);
        end
    endtask

    function automatic int field_mismatch(input string name, input logic [7:0] expected_v,
                                          input logic [7:0] actual_v);
        if (actual_v !== expected_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected_v, actual_v);
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Sampling at the rising edge: source acceptance feeds the predictor,
    // kept items are checked against the oldest prediction, register writes
    // update the shadow copy, and the watchdog counts cycles without progress.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        kept_pixel_t exp_px;
        bit          progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                downscale_pixel(s_tdata);
                items_taken++;
                progress = 1'b1;
            end

            if (m_tvalid && m_tready)
            begin
                progress = 1'b1;
                if (kept_q.size() == 0)
                begin
                    $error("kept pixel with none predicted: tdata %h, tlast %b",
                           m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_px     = kept_q.pop_front();
                    fail_count += field_mismatch("red_out",   exp_px.red,   m_tdata[7:0]);
                    fail_count += field_mismatch("green_out", exp_px.green, m_tdata[15:8]);
                    fail_count += field_mismatch("blue_out",  exp_px.blue,  m_tdata[23:16]);
                    fail_count += field_mismatch("alpha_out", exp_px.alpha, m_tdata[31:24]);
                    fail_count += field_mismatch("frame_last", 8'(exp_px.frame_last),
                                                 8'(m_tlast));
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                progress = 1'b1;
                case (paddr[3:2])
                    nnfd_pkg::REG_MAX_WIDTH:    cfg_max_w = pwdata[nnfd_pkg::SIDE_W-1:0];
                    nnfd_pkg::REG_MAX_HEIGHT:   cfg_max_h = pwdata[nnfd_pkg::SIDE_W-1:0];
                    nnfd_pkg::REG_IMAGE_WIDTH:  cfg_img_w = pwdata[nnfd_pkg::SIDE_W-1:0];
                    nnfd_pkg::REG_IMAGE_HEIGHT: cfg_img_h = pwdata[nnfd_pkg::SIDE_W-1:0];
                    default: ;
                endcase
            end

            if (progress)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL nearest_neighbor_fit_downscaler_top");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source driver, falling edge. An offered item is held until the rising
    // edge takes it; otherwise the next item from the queue goes out while
    // the current burst lasts, and the stream idles through the gap after it.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && items_taken != items_offered))
        begin
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (burst_left > 0 && pixel_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_q.pop_front();
                items_offered++;
                burst_left--;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (burst_left == 0 && gap_left > 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink, falling edge. The stall pattern is redrawn after a random run so
    // that stalls land on every phase of the frame, with open stretches too.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = $urandom_range(SINK_OPEN, SINK_BURSTY);
            sink_left = $urandom_range(40, 300);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:
                m_tready <= 1'b1;
            SINK_COIN:
                m_tready <= ($urandom_range(0, 1) == 1);
            SINK_COMB:
                m_tready <= ((sink_left % 7) < 4);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_ready = !hold_ready;
                    hold_left  = hold_ready ? $urandom_range(1, 10) : $urandom_range(1, 30);
                end
                hold_left--;
                m_tready <= hold_ready;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // One register write: a setup phase, then an access phase. The unused
    // upper data bits carry noise that the block has to ignore.
    task automatic write_reg(input logic [1:0] idx, input logic [nnfd_pkg::SIDE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(32 - nnfd_pkg::SIDE_W)'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_pixel(input logic [31:0] pix);
        pixel_q.push_back(pix);
        items_sent++;
    endtask

    task automatic queue_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            queue_pixel($urandom());
    endtask

    // Waits until every pixel was taken and every kept pixel came out, then
    // lets dropped pixels still in flight leave the pipeline.
    task automatic settle();
        do @(posedge clk); while (pixel_q.size() != 0 || s_tvalid || kept_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly small frames; now and then zero, the largest side or an
    // oversized register value.
    function automatic logic [nnfd_pkg::SIDE_W-1:0] pick_side();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return nnfd_pkg::SIDE_W'($urandom_range(0, 8191));
            2:       return nnfd_pkg::MAX_SIDE;
            default: return nnfd_pkg::SIDE_W'($urandom_range(1, 9));
        endcase
    endfunction

    // Limits around the effective side so that both fitting and pass-through
    // happen, plus the extremes.
    function automatic logic [nnfd_pkg::SIDE_W-1:0] pick_limit(input int unsigned side);
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2, 3, 4: return nnfd_pkg::SIDE_W'($urandom_range(1, side));
            5:       return nnfd_pkg::SIDE_W'($urandom_range(0, 8191));
            6:       return nnfd_pkg::MAX_SIDE;
            default: return nnfd_pkg::SIDE_W'($urandom_range(1, 3));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned                 eff_w, eff_h, frame_px, done_px, count, random_start;
        logic [nnfd_pkg::SIDE_W-1:0] w_reg, h_reg;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings describe a 1 x 1 frame: every pixel is a frame of its
        // own and carries the last flag. Channel extremes go through here.
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        settle();

        // A width of zero acts as one, giving a 1 x 2 frame.
        write_reg(nnfd_pkg::REG_IMAGE_WIDTH, nnfd_pkg::SIDE_W'(0));
        write_reg(nnfd_pkg::REG_IMAGE_HEIGHT, nnfd_pkg::SIDE_W'(2));
        queue_pixel(32'hA5A5_A5A5);
        queue_pixel(32'h5A5A_5A5A);
        settle();

        // 4 x 2 into at most 2 x 1: both candidate ratios are 1/2, so the
        // width ratio is taken and a 2 x 1 frame comes out.
        write_reg(nnfd_pkg::REG_MAX_WIDTH, nnfd_pkg::SIDE_W'(2));
        write_reg(nnfd_pkg::REG_MAX_HEIGHT, nnfd_pkg::SIDE_W'(1));
        write_reg(nnfd_pkg::REG_IMAGE_WIDTH, nnfd_pkg::SIDE_W'(4));
        queue_random(8);
        settle();

        // 3 x 1 limited to one column: the height floors to zero, so nothing
        // passes and no frame end is flagged.
        write_reg(nnfd_pkg::REG_MAX_HEIGHT, nnfd_pkg::SIDE_W'(0));
        write_reg(nnfd_pkg::REG_MAX_WIDTH, nnfd_pkg::SIDE_W'(1));
        write_reg(nnfd_pkg::REG_IMAGE_WIDTH, nnfd_pkg::SIDE_W'(3));
        write_reg(nnfd_pkg::REG_IMAGE_HEIGHT, nnfd_pkg::SIDE_W'(1));
        queue_random(3);
        settle();

        // Oversized values saturate: a 4096 wide row under a 4096 limit is
        // not scaled. Only the start of the row is sent.
        write_reg(nnfd_pkg::REG_MAX_WIDTH, nnfd_pkg::SIDE_W'(8191));
        write_reg(nnfd_pkg::REG_MAX_HEIGHT, nnfd_pkg::SIDE_W'(8191));
        write_reg(nnfd_pkg::REG_IMAGE_WIDTH, nnfd_pkg::SIDE_W'(8191));
        queue_random(4);
        settle();

        // Shrinking the width mid-row leaves the column counter past the new
        // width; it wraps on the next pixel, which then ends the frame.
        write_reg(nnfd_pkg::REG_IMAGE_WIDTH, nnfd_pkg::SIDE_W'(2));
        queue_random(3);
        settle();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            // Broken frames with SMALL_FRAME pixels or fewer left are completed,
            // on a coin toss, before the next change; the rest carry over.
            eff_w = 32'(clamp_side(cfg_img_w));
            eff_h = 32'(clamp_side(cfg_img_h));
            if ((src_col != '0 || src_row != '0) && src_col < eff_w && src_row < eff_h &&
                $urandom_range(0, 1) == 1)
            begin
                done_px  = src_row * eff_w + src_col;
                frame_px = eff_w * eff_h;
                if (frame_px - done_px <= SMALL_FRAME)
                begin
                    queue_random(frame_px - done_px);
                    settle();
                end
            end

            w_reg = pick_side();
            h_reg = pick_side();
            eff_w = 32'(clamp_side(w_reg));
            eff_h = 32'(clamp_side(h_reg));
            write_reg(nnfd_pkg::REG_IMAGE_WIDTH, w_reg);
            write_reg(nnfd_pkg::REG_IMAGE_HEIGHT, h_reg);
            write_reg(nnfd_pkg::REG_MAX_WIDTH, pick_limit(eff_w));
            write_reg(nnfd_pkg::REG_MAX_HEIGHT, pick_limit(eff_h));

            // Whole frames for small sizes, sometimes with a partial one at
            // the end; large sizes only ever see the start of a frame.
            frame_px = eff_w * eff_h;
            if (frame_px <= SMALL_FRAME)
            begin
                count = $urandom_range(1, 3) * frame_px;
                if (frame_px > 1 && $urandom_range(0, 4) == 0)
                    count += $urandom_range(1, frame_px - 1);
            end
            else
            begin
                count = $urandom_range(1, 40);
            end
            queue_random(count);
            settle();
        end

        settle();
        if (fail_count == 0)
            $display("PASS nearest_neighbor_fit_downscaler_top");
        else
            $display("FAIL nearest_neighbor_fit_downscaler_top");
        $finish;
    end

endmodule
